>>> design/xfve_pkg.sv
package xfve_pkg;

    localparam int LANES_DEFAULT = 8;
    localparam int LANE_W        = 3;
    localparam int VALUE_W       = 64;
    localparam int LZ_W          = 5;
    localparam int LEN_W         = 6;
    localparam int POS_W         = 6;
    localparam int CNT_W         = 7;
    localparam int LZ_SAT        = 31;
    localparam int HDR_REUSE     = 2;
    localparam int HDR_NEW       = 2 + LZ_W + LEN_W;

    typedef enum logic [1:0] {
        KIND_ZERO  = 2'd0,
        KIND_REUSE = 2'd1,
        KIND_NEW   = 2'd2
    } t_code_kind;

    typedef struct packed {
        logic [LANE_W-1:0]  lane;
        logic [VALUE_W-1:0] sample;
        logic               load_reference;
    } t_in_item;

    typedef struct packed {
        t_code_kind         code_kind;
        logic [LZ_W-1:0]    lead_zero_field;
        logic [LEN_W-1:0]   length_field;
        logic [VALUE_W-1:0] core_bits;
        logic [CNT_W-1:0]   core_length;
        logic [CNT_W-1:0]   total_bits;
    } t_out_item;

    // zero-count signature of a lane's last xor
    typedef struct packed {
        logic             nz;
        logic [POS_W-1:0] lead;
        logic [POS_W-1:0] trail;
    } t_xor_sig;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        t_xor_sig           sig;
    } t_lane_entry;

    function automatic logic [CNT_W-1:0] count_lead(input logic [VALUE_W-1:0] x);
        logic [CNT_W-1:0] n;
        logic             hit;
        n   = CNT_W'(VALUE_W);
        hit = 1'b0;
        for (int i = VALUE_W - 1; i >= 0; i--) begin
            if (!hit && x[i]) begin
                n   = CNT_W'(VALUE_W - 1 - i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [CNT_W-1:0] count_trail(input logic [VALUE_W-1:0] x);
        logic [CNT_W-1:0] n;
        logic             hit;
        n   = CNT_W'(VALUE_W);
        hit = 1'b0;
        for (int i = 0; i < VALUE_W; i++) begin
            if (!hit && x[i]) begin
                n   = CNT_W'(i);
                hit = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

>>> design/xfve_encode.sv
module xfve_encode (
    input  logic [xfve_pkg::VALUE_W-1:0] i_sample,
    input  xfve_pkg::t_lane_entry        i_prev,
    output xfve_pkg::t_out_item          o_item,
    output xfve_pkg::t_xor_sig           o_sig
);

    logic [xfve_pkg::VALUE_W-1:0] x;
    logic [xfve_pkg::CNT_W-1:0]   lz;
    logic [xfve_pkg::CNT_W-1:0]   tz;
    logic [xfve_pkg::LZ_W-1:0]    sat_lz;
    logic [xfve_pkg::CNT_W-1:0]   len;
    logic                         match;

    assign x  = i_sample ^ i_prev.value;
    assign lz = xfve_pkg::count_lead(x);
    assign tz = xfve_pkg::count_trail(x);

    assign sat_lz = (lz > xfve_pkg::CNT_W'(xfve_pkg::LZ_SAT))
                  ? xfve_pkg::LZ_W'(xfve_pkg::LZ_SAT) : lz[xfve_pkg::LZ_W-1:0];
    assign len    = xfve_pkg::CNT_W'(xfve_pkg::VALUE_W)
                  - xfve_pkg::CNT_W'(sat_lz) - tz;
    assign match  = i_prev.sig.nz
                  && (i_prev.sig.lead == lz[xfve_pkg::POS_W-1:0])
                  && (i_prev.sig.trail == tz[xfve_pkg::POS_W-1:0]);

    assign o_sig.nz    = |x;
    assign o_sig.lead  = lz[xfve_pkg::POS_W-1:0];
    assign o_sig.trail = tz[xfve_pkg::POS_W-1:0];

    always_comb begin
        o_item = '0;
        if (x == '0) begin
            o_item.code_kind  = xfve_pkg::KIND_ZERO;
            o_item.total_bits = xfve_pkg::CNT_W'(1);
        end else begin
            o_item.core_bits   = x >> tz;
            o_item.core_length = len;
            if (match) begin
                o_item.code_kind  = xfve_pkg::KIND_REUSE;
                o_item.total_bits = len + xfve_pkg::CNT_W'(xfve_pkg::HDR_REUSE);
            end else begin
                o_item.code_kind       = xfve_pkg::KIND_NEW;
                o_item.lead_zero_field = sat_lz;
                o_item.length_field    = len[xfve_pkg::LEN_W-1:0];
                o_item.total_bits      = len + xfve_pkg::CNT_W'(xfve_pkg::HDR_NEW);
            end
        end
    end

endmodule

>>> design/xor_float_value_encoder.sv
// XOR value encoder for float series, one code word description per beat.
// Input channel (i_in_valid / o_in_stall / i_in_data): lane, raw 64-bit sample
// and a load flag. A load beat stores the sample as the lane reference and
// gives no output; a lane at or above LANES is dropped. Every other beat gives
// one output beat (o_out_valid / i_out_stall / o_out_data): code kind, header
// fields, core bits, core length and total bit count; packing is downstream.
// Accepted beats pass the lane stage register, then the output register.
// Throughput: one beat per cycle unless stalled, set by the lane memory
// read-modify-write (synchronous read, stage write-back, last write forwarded).
// Reset: i_rst_n synchronous, active low; all lane state reads as zero after
// reset through per-lane valid bits, no clearing pass. Output register empty.
// When the receiver stalls, the output beat holds; one more beat can sit in the
// lane stage before o_in_stall rises. Load beats drain even under stall.
module xor_float_value_encoder #(
    parameter int LANES = xfve_pkg::LANES_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  xfve_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output xfve_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);

    localparam int AW = (LANES > 1) ? $clog2(LANES) : 1;

    xfve_pkg::t_lane_entry r_mem [LANES];
    logic [LANES-1:0]      r_entry_valid;

    xfve_pkg::t_lane_entry r_rd_entry;
    logic                  r_rd_valid;
    logic                  r_s1_valid;
    xfve_pkg::t_in_item    r_s1_item;
    logic [AW-1:0]         r_s1_addr;
    logic                  r_fwd_valid;
    logic [AW-1:0]         r_fwd_addr;
    xfve_pkg::t_lane_entry r_fwd_entry;
    logic                  r_out_valid;
    xfve_pkg::t_out_item   r_out_data;

    logic [xfve_pkg::LANE_W+AW-1:0] in_lane_ext;
    logic [AW-1:0]                  in_addr;
    logic                           in_lane_ok;
    logic                           out_free;
    logic                           s1_adv;
    logic                           in_ready;
    logic                           in_acc;
    xfve_pkg::t_lane_entry          prev;
    xfve_pkg::t_lane_entry          wr_entry;
    xfve_pkg::t_out_item            enc_item;
    xfve_pkg::t_xor_sig             enc_sig;

    assign in_lane_ext = {{AW{1'b0}}, i_in_data.lane};
    assign in_addr     = in_lane_ext[AW-1:0];
    assign in_lane_ok  = int'(i_in_data.lane) < LANES;

    assign out_free = !r_out_valid || !i_out_stall;
    assign s1_adv   = r_s1_valid && (r_s1_item.load_reference || out_free);
    assign in_ready = !r_s1_valid || s1_adv;
    assign in_acc   = i_in_valid && in_ready;

    // last write may land on the edge that read this lane
    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == r_s1_addr)) begin
            prev = r_fwd_entry;
        end else if (r_rd_valid) begin
            prev = r_rd_entry;
        end else begin
            prev = '0;
        end
    end

    xfve_encode u_encode (
        .i_sample (r_s1_item.sample),
        .i_prev   (prev),
        .o_item   (enc_item),
        .o_sig    (enc_sig)
    );

    always_comb begin
        wr_entry.value = r_s1_item.sample;
        wr_entry.sig   = r_s1_item.load_reference ? '0 : enc_sig;
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_mem[r_s1_addr] <= wr_entry;
            r_fwd_addr       <= r_s1_addr;
            r_fwd_entry      <= wr_entry;
        end
        if (in_acc && in_lane_ok) begin
            r_rd_entry <= r_mem[in_addr];
            r_s1_item  <= i_in_data;
            r_s1_addr  <= in_addr;
        end
        if (s1_adv && !r_s1_item.load_reference) begin
            r_out_data <= enc_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_rd_valid    <= 1'b0;
            r_s1_valid    <= 1'b0;
            r_fwd_valid   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_entry_valid[r_s1_addr] <= 1'b1;
                r_fwd_valid              <= 1'b1;
            end
            if (in_acc && in_lane_ok) begin
                r_rd_valid <= r_entry_valid[in_addr];
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && !r_s1_item.load_reference) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.code_kind == xfve_pkg::KIND_ZERO)
        |-> (o_out_data.total_bits == xfve_pkg::CNT_W'(1))
            && (o_out_data.core_length == '0))
        else $error("zero xor word with nonzero length");

    a_new_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.code_kind == xfve_pkg::KIND_NEW)
        |-> (o_out_data.total_bits
             == xfve_pkg::CNT_W'(o_out_data.core_length
                                 + xfve_pkg::CNT_W'(xfve_pkg::HDR_NEW)))
            && (o_out_data.length_field
             == o_out_data.core_length[xfve_pkg::LEN_W-1:0]))
        else $error("new window word length mismatch");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_item.load_reference && out_free
        |=> !o_out_valid)
        else $error("reference load produced an output beat");

endmodule
